>>> rtl/core/dual_channel_fir_lowpass_macros.svh
// assertion macros for the dual channel fir low-pass filter
// expects signals named clock and reset in the module that uses them
`ifndef DUAL_CHANNEL_FIR_LOWPASS_MACROS_SVH
`define DUAL_CHANNEL_FIR_LOWPASS_MACROS_SVH

// same-cycle implication
`define DCFL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DCFL_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/dcfl_pkg.sv
// shared types, constants and coefficient table of the dual channel fir low-pass filter
// no dependencies
package dcfl_pkg;

   localparam int TS_W         = 32;
   localparam int IN_SAMPLE_W  = 18;
   localparam int OUT_W        = 20;
   localparam int REQ_TDATA_W  = 72;
   localparam int RSP_TDATA_W  = 72;
   localparam int TBL_SIZE     = 64;
   localparam int TBL_IDX_W    = 6;
   localparam int BASE_FRAC    = 15;

   // q1.15 coefficients, position 0 multiplies the oldest sample
   localparam logic signed [15:0] COEF_Q15 [TBL_SIZE] = '{
      -16'sd256, -16'sd258, -16'sd356, -16'sd450, -16'sd524, -16'sd559, -16'sd540,
      -16'sd450, -16'sd276, -16'sd14, 16'sd336, 16'sd762, 16'sd1249, 16'sd1768,
      16'sd2290, 16'sd2780, 16'sd3205, 16'sd3533, 16'sd3740, 16'sd3811, 16'sd3740,
      16'sd3533, 16'sd3205, 16'sd2780, 16'sd2290, 16'sd1768, 16'sd1249, 16'sd762,
      16'sd336, -16'sd14, -16'sd276, -16'sd450, -16'sd540, -16'sd559, -16'sd524,
      -16'sd450, -16'sd356, -16'sd258, -16'sd256,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
   };

   // per-cycle controls from the sequencer to each channel's mac
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
      logic rnd_en;
      logic sat_en;
   } mac_ctrl_type;

   // coefficient rescaled to frac fraction bits, round half away from zero when narrowing
   function automatic logic signed [31:0] coef_at(input logic [TBL_IDX_W-1:0] idx,
                                                  input int frac);
      logic signed [31:0] c;
      logic [31:0]        m;
      logic               neg;
      int                 d;
      c   = 32'(COEF_Q15[idx]);
      neg = c[31];
      if (frac >= BASE_FRAC) begin
         return c <<< (frac - BASE_FRAC);
      end
      d = BASE_FRAC - frac;
      m = neg ? 32'(-c) : 32'(c);
      m = (m + (32'd1 << (d - 1))) >> d;
      return neg ? -$signed(m) : $signed(m);
   endfunction

endpackage

>>> rtl/core/dcfl_cell.sv
// one delay-line cell: holds a red/infrared sample pair, loads from its neighbor
// depends on nothing but its parameter
module dcfl_cell #(
   parameter int W = 36
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         shift_en,
   input  logic [W-1:0] d_in,
   output logic [W-1:0] q
);

   logic [W-1:0] data_ff;
   logic [W-1:0] data_in;

   assign data_in = shift_en ? d_in : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;

endmodule

>>> rtl/core/dcfl_mac.sv
// one channel's multiply-accumulate, rounding and saturation, with result register
// depends on dcfl_pkg
module dcfl_mac #(
   parameter int SAMPLE_BITS = 18,
   parameter int COEF_W      = 16,
   parameter int FRAC_BITS   = 15,
   parameter int TAPS        = 39
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dcfl_pkg::mac_ctrl_type        ctrl,
   input  logic [SAMPLE_BITS-1:0]        sample,
   input  logic signed [COEF_W-1:0]      coef,
   output logic [dcfl_pkg::OUT_W-1:0]    result
);

   localparam int PROD_W = SAMPLE_BITS + 1 + COEF_W;
   localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
   localparam int RND_W  = ACC_W + 1;
   localparam int OUT_W  = dcfl_pkg::OUT_W;
   localparam logic [RND_W-1:0] POS_LIM = RND_W'((1 << (OUT_W - 1)) - 1);
   localparam logic [RND_W-1:0] NEG_LIM = RND_W'(1 << (OUT_W - 1));
   localparam logic [RND_W-1:0] HALF    = RND_W'(1) << (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [RND_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff;
   logic [OUT_W-1:0]         result_ff, result_in;
   logic [RND_W-1:0]         abs_acc;

   assign prod_in = $signed({1'b0, sample}) * coef;
   assign acc_in  = acc_ff + ACC_W'(prod_ff);

   // magnitude rounded to whole sample units
   assign abs_acc = acc_ff[ACC_W-1] ? RND_W'(-acc_ff) : RND_W'(acc_ff);
   assign mag_in  = (abs_acc + HALF) >> FRAC_BITS;

   always_comb begin
      if (neg_ff) begin
         result_in = (mag_ff > NEG_LIM) ? OUT_W'(NEG_LIM) : OUT_W'(-mag_ff);
      end else begin
         result_in = (mag_ff > POS_LIM) ? OUT_W'(POS_LIM) : mag_ff[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff   <= '0;
         acc_ff    <= '0;
         mag_ff    <= '0;
         neg_ff    <= 1'b0;
         result_ff <= '0;
      end else begin
         if (ctrl.mul_en) begin
            prod_ff <= prod_in;
         end
         if (ctrl.clear) begin
            acc_ff <= '0;
         end else if (ctrl.acc_en) begin
            acc_ff <= acc_in;
         end
         if (ctrl.rnd_en) begin
            mag_ff <= mag_in;
            neg_ff <= acc_ff[ACC_W-1];
         end
         if (ctrl.sat_en) begin
            result_ff <= result_in;
         end
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/core/dual_channel_fir_lowpass.sv
// an item's transfer starts ST_MAC for each tap, then ST_TAIL, ST_ROUND and ST_EMIT
//   ST_EMIT waits for a free output register, then raises rsp_tvalid; items are taken
//   only in ST_IDLE, as the single mac per channel walks the delay line one tap per cycle
// reset: synchronous, active high; clears both delay lines to zero and drops rsp_tvalid
// a finished result waits in the output register while the next item is taken
`include "dual_channel_fir_lowpass_macros.svh"
module dual_channel_fir_lowpass #(
   parameter int TAPS           = 39,
   parameter int SAMPLE_BITS    = 18,
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] time_stamp, [49:32] red_sample, [67:50] ir_sample, [71:68] zero
   input  logic [dcfl_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] time_stamp_out, [51:32] red_filtered, [71:52] ir_filtered
   output logic [dcfl_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int TS_W   = dcfl_pkg::TS_W;
   localparam int IN_W   = dcfl_pkg::IN_SAMPLE_W;
   localparam int OUT_W  = dcfl_pkg::OUT_W;
   localparam int CELL_W = 2 * SAMPLE_BITS;
   localparam int CNT_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int COEF_W = COEF_FRAC_BITS + 1;
   localparam logic [CNT_W-1:0] LAST_TAP = CNT_W'(TAPS - 1);

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MAC   = 5'b00010,
      ST_TAIL  = 5'b00100,
      ST_ROUND = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [TS_W-1:0]        ts_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TS_W-1:0]        ts_out_ff;

   logic                   req_fire;
   logic                   out_free;
   logic                   shift_en;
   logic [CELL_W-1:0]      tail_in;
   logic [CELL_W-1:0]      new_pair;
   logic [CELL_W-1:0]      line_q [TAPS];
   logic signed [31:0]     coef_full;
   logic signed [COEF_W-1:0] coef;
   dcfl_pkg::mac_ctrl_type ctrl;
   logic [OUT_W-1:0]       red_res, ir_res;
   logic                   mac_last;
   logic                   emit_stall;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   // output register can take a result when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // input fields: bits above SAMPLE_BITS are dropped
   assign new_pair = {SAMPLE_BITS'(req_tdata[TS_W+2*IN_W-1:TS_W+IN_W]),
                      SAMPLE_BITS'(req_tdata[TS_W+IN_W-1:TS_W])};

   // delay line: shifts in the new pair on a transfer, then rotates once per tap
   // so cell 0 presents the samples oldest first and the line ends in order
   assign shift_en = req_fire || (state_ff == ST_MAC);
   assign tail_in  = req_fire ? new_pair : line_q[0];

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      logic [CELL_W-1:0] d_in;
      if (i == TAPS - 1) begin : g_tail
         assign d_in = tail_in;
      end else begin : g_body
         assign d_in = line_q[i+1];
      end
      dcfl_cell #(
         .W (CELL_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .d_in     (d_in),
         .q        (line_q[i])
      );
   end

   // coefficient rom, indexed by the tap counter
   assign coef_full = dcfl_pkg::coef_at(dcfl_pkg::TBL_IDX_W'(cnt_ff), COEF_FRAC_BITS);
   assign coef      = coef_full[COEF_W-1:0];

   // mac controls
   always_comb begin
      ctrl.clear  = req_fire;
      ctrl.mul_en = (state_ff == ST_MAC);
      ctrl.acc_en = ((state_ff == ST_MAC) && (cnt_ff != '0)) || (state_ff == ST_TAIL);
      ctrl.rnd_en = (state_ff == ST_ROUND);
      ctrl.sat_en = (state_ff == ST_EMIT) && out_free;
   end

   dcfl_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_W      (COEF_W),
      .FRAC_BITS   (COEF_FRAC_BITS),
      .TAPS        (TAPS)
   ) u_mac_red (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (line_q[0][SAMPLE_BITS-1:0]),
      .coef   (coef),
      .result (red_res)
   );

   dcfl_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_W      (COEF_W),
      .FRAC_BITS   (COEF_FRAC_BITS),
      .TAPS        (TAPS)
   ) u_mac_ir (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (line_q[0][CELL_W-1:SAMPLE_BITS]),
      .coef   (coef),
      .result (ir_res)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MAC;
               cnt_in   = '0;
            end
         end
         ST_MAC: begin
            if (cnt_ff == LAST_TAP) begin
               state_in = ST_TAIL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_TAIL: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // time stamp rides along with the item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ts_ff <= req_tdata[TS_W-1:0];
      end
      if (ctrl.sat_en) begin
         ts_out_ff <= ts_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {ir_res, red_res, ts_out_ff};

   // checks
   assign mac_last   = (state_ff == ST_MAC) && (cnt_ff == LAST_TAP);
   assign emit_stall = (state_ff == ST_EMIT) && !out_free;

   `DCFL_ASSERT_IMP(a_cnt_range, state_ff == ST_MAC, cnt_ff <= LAST_TAP, "tap counter out of range")
   `DCFL_ASSERT_NXT(a_start_mac, req_fire, state_ff == ST_MAC && cnt_ff == '0, "item did not start mac")
   `DCFL_ASSERT_NXT(a_mac_done, mac_last, state_ff == ST_TAIL, "mac overran last tap")
   `DCFL_ASSERT_NXT(a_emit_hold, emit_stall, state_ff == ST_EMIT, "result left while output full")

endmodule
